// ===== design/yfsu_pkg.sv =====
// shared types and constants for the yee field stencil update core
package yfsu_pkg;

  // default geometry and number format
  localparam int DEF_MAX_EXTENT_X = 64;
  localparam int DEF_MAX_EXTENT_Y = 64;
  localparam int DEF_FRAC_BITS    = 16;

  // fixed field widths
  localparam int FIELD_W     = 32;
  localparam int SCALE_W     = 17;
  localparam int EXT_W       = 7;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;

  // register indexes on the configuration channel
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SWEEP_KIND    = 3'd0,
    REG_SCALE_X       = 3'd1,
    REG_SCALE_Y       = 3'd2,
    REG_SCALE_Z       = 3'd3,
    REG_CURRENT_SCALE = 3'd4,
    REG_EXTENT_X      = 3'd5,
    REG_EXTENT_Y      = 3'd6
  } cfg_reg_t;

  // one grid cell in
  typedef struct packed {
    logic                      sweep_start;
    logic signed [FIELD_W-1:0] elec_x;
    logic signed [FIELD_W-1:0] elec_y;
    logic signed [FIELD_W-1:0] elec_z;
    logic signed [FIELD_W-1:0] mag_x;
    logic signed [FIELD_W-1:0] mag_y;
    logic signed [FIELD_W-1:0] mag_z;
    logic signed [FIELD_W-1:0] cur_x;
    logic signed [FIELD_W-1:0] cur_y;
    logic signed [FIELD_W-1:0] cur_z;
  } item_t;

  // one updated cell out
  typedef struct packed {
    logic signed [FIELD_W-1:0] new_x;
    logic signed [FIELD_W-1:0] new_y;
    logic signed [FIELD_W-1:0] new_z;
    logic                      was_updated;
    logic                      saturated;
  } result_t;

endpackage

// ===== design/yfsu_ram.sv =====
// generic single-write, single-read ram with registered read data
module yfsu_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/yee_field_stencil_update_core.sv =====
// yee leapfrog half-step core: one grid cell per beat, e or h update
//
//   channel   direction  handshake                payload
//   item      in         item_valid / item_ready  item (item_t)
//   result    out        result_valid/result_ready result (result_t)
//   cfg       in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// one cell per cycle sustained while results are taken; an item beat passes through the
// stage 1 register with neighbor memory read, product register and output register.
// rst clears positions, previous-cell register, config and pipeline valids; the
// row and plane delay memories are not cleared and need no clearing pass.
// a stalled result holds the pipeline; item_ready drops only when all three
// registers are full and the result beat is not taken. cfg_ready is always high.
module yee_field_stencil_update_core
  import yfsu_pkg::*;
#(
  parameter int MAX_EXTENT_X = DEF_MAX_EXTENT_X,
  parameter int MAX_EXTENT_Y = DEF_MAX_EXTENT_Y,
  parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  item_t                  item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int XW          = $clog2(MAX_EXTENT_X);
  localparam int YW          = $clog2(MAX_EXTENT_Y);
  localparam int EXW         = $clog2(MAX_EXTENT_X + 1);
  localparam int EYW         = $clog2(MAX_EXTENT_Y + 1);
  localparam int PLANE_DEPTH = MAX_EXTENT_X * MAX_EXTENT_Y;
  localparam int PAW         = $clog2(PLANE_DEPTH);
  localparam int VEC_W       = 3 * FIELD_W;
  localparam int DIFF_W      = FIELD_W + 1;
  localparam int PROD_W      = SCALE_W + 1 + DIFF_W;
  localparam int CURL_W      = PROD_W + 1;
  localparam int BASE_W      = FIELD_W + FRAC_BITS;
  localparam int ACC_W       = ((BASE_W > CURL_W) ? BASE_W : CURL_W) + 2;
  localparam int RND_W       = ACC_W - FRAC_BITS;

  localparam logic signed [RND_W-1:0] R_MAX = RND_W'(signed'(32'h7fffffff));
  localparam logic signed [RND_W-1:0] R_MIN = RND_W'(signed'(32'h80000000));
  localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(1) <<< (FRAC_BITS - 1);

  // configuration registers
  logic               sweep_kind;
  logic [SCALE_W-1:0] scale_x, scale_y, scale_z, current_scale;
  logic [EXT_W-1:0]   extent_x, extent_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_kind    <= 1'b0;
      scale_x       <= '0;
      scale_y       <= '0;
      scale_z       <= '0;
      current_scale <= '0;
      extent_x      <= EXT_W'(1);
      extent_y      <= EXT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_SWEEP_KIND:    sweep_kind    <= cfg_data[0];
        REG_SCALE_X:       scale_x       <= cfg_data[SCALE_W-1:0];
        REG_SCALE_Y:       scale_y       <= cfg_data[SCALE_W-1:0];
        REG_SCALE_Z:       scale_z       <= cfg_data[SCALE_W-1:0];
        REG_CURRENT_SCALE: current_scale <= cfg_data[SCALE_W-1:0];
        REG_EXTENT_X:      extent_x      <= cfg_data[EXT_W-1:0];
        REG_EXTENT_Y:      extent_y      <= cfg_data[EXT_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake chain through the three stages
  logic accept, s1_valid, s2_valid, out_move, s2_free, s1_free;

  assign out_move   = !result_valid || result_ready;
  assign s2_free    = !s2_valid || out_move;
  assign s1_free    = !s1_valid || s2_free;
  assign item_ready = s1_free;
  assign accept     = item_valid && item_ready;

  // clamped extents
  logic [EXW-1:0] ex;
  logic [EYW-1:0] ey;
  logic           x_on, y_on;

  always_comb begin
    if (extent_x == '0) begin
      ex = EXW'(1);
    end else if (32'(extent_x) > MAX_EXTENT_X) begin
      ex = EXW'(MAX_EXTENT_X);
    end else begin
      ex = EXW'(extent_x);
    end
    if (extent_y == '0) begin
      ey = EYW'(1);
    end else if (32'(extent_y) > MAX_EXTENT_Y) begin
      ey = EYW'(MAX_EXTENT_Y);
    end else begin
      ey = EYW'(extent_y);
    end
  end

  assign x_on = ex > EXW'(1);
  assign y_on = ey > EYW'(1);

  // raster position of the arriving cell and the one after it
  logic [XW-1:0]  pos_x, pos_x_next, px0, cur_px;
  logic [YW-1:0]  pos_y, pos_y_next, py0, cur_py;
  logic           past_first_plane, past_first_plane_next, pfp0;
  logic [EXW-1:0] px_inc;
  logic [EYW-1:0] py_inc;
  logic           cell_upd;
  logic [PAW-1:0] plane_addr;

  always_comb begin
    px0    = item.sweep_start ? '0 : pos_x;
    py0    = item.sweep_start ? '0 : pos_y;
    pfp0   = item.sweep_start ? 1'b0 : past_first_plane;
    cur_px = (EXW'(px0) >= ex) ? '0 : px0;
    cur_py = (EYW'(py0) >= ey) ? '0 : py0;
    px_inc = EXW'(cur_px) + EXW'(1);
    py_inc = EYW'(cur_py) + EYW'(1);
    if (px_inc >= ex) begin
      pos_x_next = '0;
      if (py_inc >= ey) begin
        pos_y_next            = '0;
        past_first_plane_next = 1'b1;
      end else begin
        pos_y_next            = py_inc[YW-1:0];
        past_first_plane_next = pfp0;
      end
    end else begin
      pos_x_next            = px_inc[XW-1:0];
      pos_y_next            = cur_py;
      past_first_plane_next = pfp0;
    end
    cell_upd   = pfp0 && !(x_on && cur_px == '0) && !(y_on && cur_py == '0);
    plane_addr = PAW'(32'(cur_py) * MAX_EXTENT_X) + PAW'(cur_px);
  end

  // swept field and the other field of the arriving cell
  logic signed [FIELD_W-1:0] in_f [3];
  logic signed [FIELD_W-1:0] in_o [3];
  logic signed [FIELD_W-1:0] in_j [3];
  logic [VEC_W-1:0]          o_vec;

  always_comb begin
    in_f[0] = sweep_kind ? item.mag_x : item.elec_x;
    in_f[1] = sweep_kind ? item.mag_y : item.elec_y;
    in_f[2] = sweep_kind ? item.mag_z : item.elec_z;
    in_o[0] = sweep_kind ? item.elec_x : item.mag_x;
    in_o[1] = sweep_kind ? item.elec_y : item.mag_y;
    in_o[2] = sweep_kind ? item.elec_z : item.mag_z;
    in_j[0] = item.cur_x;
    in_j[1] = item.cur_y;
    in_j[2] = item.cur_z;
    o_vec   = {in_o[2], in_o[1], in_o[0]};
  end

  // row and plane delay lines, written and read at the item beat
  logic [VEC_W-1:0] row_rd, plane_rd;

  yfsu_ram #(.WIDTH(VEC_W), .DEPTH(MAX_EXTENT_X)) u_row_ram (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (cur_px),
    .wr_data (o_vec),
    .rd_en   (accept),
    .rd_addr (cur_px),
    .rd_data (row_rd)
  );

  yfsu_ram #(.WIDTH(VEC_W), .DEPTH(PLANE_DEPTH)) u_plane_ram (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (plane_addr),
    .wr_data (o_vec),
    .rd_en   (accept),
    .rd_addr (plane_addr),
    .rd_data (plane_rd)
  );

  // position state and previous-cell register
  logic signed [FIELD_W-1:0] prev_o [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x            <= '0;
      pos_y            <= '0;
      past_first_plane <= 1'b0;
      prev_o           <= '{default: '0};
    end else if (accept) begin
      pos_x            <= pos_x_next;
      pos_y            <= pos_y_next;
      past_first_plane <= past_first_plane_next;
      prev_o           <= in_o;
    end
  end

  // stage 1: cell captured alongside the memory reads
  logic signed [FIELD_W-1:0] s1_f [3];
  logic signed [FIELD_W-1:0] s1_o [3];
  logic signed [FIELD_W-1:0] s1_j [3];
  logic signed [FIELD_W-1:0] s1_nx [3];
  logic                      s1_upd, s1_mag, s1_x_on, s1_y_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_f    <= in_f;
      s1_o    <= in_o;
      s1_j    <= in_j;
      s1_nx   <= prev_o;
      s1_upd  <= cell_upd;
      s1_mag  <= sweep_kind;
      s1_x_on <= x_on;
      s1_y_on <= y_on;
    end
  end

  // neighbor differences and scaled products
  logic signed [DIFF_W-1:0] dx [3];
  logic signed [DIFF_W-1:0] dy [3];
  logic signed [DIFF_W-1:0] dz [3];
  logic signed [FIELD_W-1:0] ny, nz;
  logic signed [PROD_W-1:0] p_next [6];
  logic signed [PROD_W-1:0] q_next [3];
  logic signed [PROD_W-1:0] cx, cy, cz, cs;

  always_comb begin
    cx = PROD_W'($signed({1'b0, scale_x}));
    cy = PROD_W'($signed({1'b0, scale_y}));
    cz = PROD_W'($signed({1'b0, scale_z}));
    cs = PROD_W'($signed({1'b0, current_scale}));
    for (int i = 0; i < 3; i++) begin
      ny = $signed(row_rd[FIELD_W*i +: FIELD_W]);
      nz = $signed(plane_rd[FIELD_W*i +: FIELD_W]);
      if (!s1_x_on) begin
        dx[i] = '0;
      end else if (s1_mag) begin
        dx[i] = DIFF_W'(s1_nx[i]) - DIFF_W'(s1_o[i]);
      end else begin
        dx[i] = DIFF_W'(s1_o[i]) - DIFF_W'(s1_nx[i]);
      end
      if (!s1_y_on) begin
        dy[i] = '0;
      end else if (s1_mag) begin
        dy[i] = DIFF_W'(ny) - DIFF_W'(s1_o[i]);
      end else begin
        dy[i] = DIFF_W'(s1_o[i]) - DIFF_W'(ny);
      end
      if (s1_mag) begin
        dz[i] = DIFF_W'(nz) - DIFF_W'(s1_o[i]);
      end else begin
        dz[i] = DIFF_W'(s1_o[i]) - DIFF_W'(nz);
      end
      q_next[i] = cs * PROD_W'(s1_j[i]);
    end
    p_next[0] = cy * PROD_W'(dy[2]);
    p_next[1] = cz * PROD_W'(dz[1]);
    p_next[2] = cz * PROD_W'(dz[0]);
    p_next[3] = cx * PROD_W'(dx[2]);
    p_next[4] = cx * PROD_W'(dx[1]);
    p_next[5] = cy * PROD_W'(dy[0]);
  end

  // stage 2: registered products
  logic signed [PROD_W-1:0]  s2_p [6];
  logic signed [PROD_W-1:0]  s2_q [3];
  logic signed [FIELD_W-1:0] s2_f [3];
  logic                      s2_upd, s2_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_free) begin
      s2_p   <= p_next;
      s2_q   <= q_next;
      s2_f   <= s1_f;
      s2_upd <= s1_upd;
      s2_mag <= s1_mag;
    end
  end

  // curl sum, round half up and saturate
  logic signed [CURL_W-1:0]  curl [3];
  logic signed [ACC_W-1:0]   acc;
  logic signed [RND_W-1:0]   rnd;
  logic signed [FIELD_W-1:0] res [3];
  logic                      sat_any;

  always_comb begin
    curl[0] = CURL_W'(s2_p[0]) - CURL_W'(s2_p[1]);
    curl[1] = CURL_W'(s2_p[2]) - CURL_W'(s2_p[3]);
    curl[2] = CURL_W'(s2_p[4]) - CURL_W'(s2_p[5]);
    sat_any = 1'b0;
    acc     = '0;
    rnd     = '0;
    for (int i = 0; i < 3; i++) begin
      if (s2_mag) begin
        acc = (ACC_W'(s2_f[i]) <<< FRAC_BITS) - ACC_W'(curl[i]);
      end else begin
        acc = (ACC_W'(s2_f[i]) <<< FRAC_BITS) + ACC_W'(curl[i]) - ACC_W'(s2_q[i]);
      end
      rnd = RND_W'((acc + HALF) >>> FRAC_BITS);
      if (!s2_upd) begin
        res[i] = s2_f[i];
      end else if (rnd > R_MAX) begin
        res[i]  = R_MAX[FIELD_W-1:0];
        sat_any = 1'b1;
      end else if (rnd < R_MIN) begin
        res[i]  = R_MIN[FIELD_W-1:0];
        sat_any = 1'b1;
      end else begin
        res[i] = rnd[FIELD_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_move) begin
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && out_move) begin
      result.new_x       <= res[0];
      result.new_y       <= res[1];
      result.new_z       <= res[2];
      result.was_updated <= s2_upd;
      result.saturated   <= sat_any;
    end
  end

endmodule

// ===== design/yfsu_checker.sv =====
// port-level checks for the yee field stencil update core, bound to the top level
module yfsu_checker
  import yfsu_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  localparam logic signed [FIELD_W-1:0] F_MAX = 32'sh7fffffff;
  localparam logic signed [FIELD_W-1:0] F_MIN = 32'sh80000000;

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // a stalled result beat keeps its valid
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped while stalled");

  // boundary cells pass through and never clip
  a_pass_no_sat: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.was_updated |-> !result.saturated)
    else $error("saturation flagged on pass-through cell");

  // a clipped beat carries a rail value in some component
  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.saturated |->
      (result.new_x == F_MAX || result.new_x == F_MIN ||
       result.new_y == F_MAX || result.new_y == F_MIN ||
       result.new_z == F_MAX || result.new_z == F_MIN))
    else $error("saturation flag without a clipped component");

endmodule

bind yee_field_stencil_update_core yfsu_checker u_yfsu_checker (.*);
